// ===== src/gdd_pkg.sv =====
// Package for the Gregorian date difference block.
// Holds the field widths, the month tables and the per-date stage records.
// No dependencies.
package gdd_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int COUNT_W  = 22;
   localparam int DAYNUM_W = 23;
   localparam int DOY_W    = 9;
   localparam int CENT_W   = 8;
   localparam int YCMP_W   = 17;
   localparam int PROD_W   = 25;
   localparam int RECIP_SH = 17;

   // floor(q / 25) equals (q * RECIP_25) >> RECIP_SH for every q below 4096.
   localparam logic [12:0] RECIP_25 = 13'd5243;

   localparam logic [MONTH_W-1:0]  MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0]  MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]    FEB_LEAP_DAY = 5'd29;
   localparam logic [COUNT_W-1:0]  COUNT_MAX = 22'h3F_FFFF;
   localparam logic [DAYNUM_W-1:0] DAYS_PER_YEAR = 23'd365;
   localparam logic [15:0]         YEARS_PER_CENT = 16'd100;

   typedef struct packed {
      logic [PROD_W-1:0] prod_p;   // (year-1)/4 times the reciprocal of 25
      logic [PROD_W-1:0] prod_y;   // year/4 times the reciprocal of 25
      logic [YEAR_W-1:0] prev_yr;  // year minus one
      logic [YEAR_W-1:0] yr;
      logic              base_ok;  // year and month nonzero and in range, day nonzero
      logic              fit;      // day fits the common-year month length
      logic              feb29;
      logic [DOY_W-1:0]  doy;      // days before the month plus day of month
      logic              late;     // month after February
   } s1_lane_type;

   typedef struct packed {
      logic [DAYNUM_W-1:0] nyear;  // days in all whole years before this one
      logic [DOY_W-1:0]    doy;
      logic                leap_add;
      logic                ok;
   } s2_lane_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== src/gregorian_date_difference.sv =====
// rsp_valid rises once an accepted transaction has passed s1_ff, s2_ff and s3_num_ff into the output register.
// Throughput: one date pair per cycle while rsp_stall is low; the four register stages hold one pair each.
// rsp_stall holds the output and fills the stages behind it before req_stall rises.
// Reset (synchronous, active high) clears the stage valid bits only.
// Top level of the Gregorian date difference block; depends on gdd_pkg.
// Day numbers come from closed-form year, century and month sums per date.
module gregorian_date_difference #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [gdd_pkg::DAY_W-1:0]    req_first_day,
   input  logic [gdd_pkg::MONTH_W-1:0]  req_first_month,
   input  logic [gdd_pkg::YEAR_W-1:0]   req_first_year,
   input  logic [gdd_pkg::DAY_W-1:0]    req_second_day,
   input  logic [gdd_pkg::MONTH_W-1:0]  req_second_month,
   input  logic [gdd_pkg::YEAR_W-1:0]   req_second_year,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gdd_pkg::COUNT_W-1:0]  rsp_day_count,
   output logic                         rsp_dates_valid
);

   logic [gdd_pkg::DAY_W-1:0]   day   [2];
   logic [gdd_pkg::MONTH_W-1:0] month [2];
   logic [gdd_pkg::YEAR_W-1:0]  year  [2];

   gdd_pkg::s1_lane_type s1_in [2];
   gdd_pkg::s1_lane_type s1_ff [2];
   gdd_pkg::s2_lane_type s2_in [2];
   gdd_pkg::s2_lane_type s2_ff [2];
   logic [gdd_pkg::DAYNUM_W-1:0] s3_num_in [2];
   logic [gdd_pkg::DAYNUM_W-1:0] s3_num_ff [2];
   logic                         s3_ok_in;
   logic                         s3_ok_ff;
   logic [gdd_pkg::DAYNUM_W-1:0] diff;
   logic [gdd_pkg::COUNT_W-1:0]  rsp_day_count_in;
   logic [gdd_pkg::COUNT_W-1:0]  rsp_day_count_ff;
   logic                         rsp_dates_valid_ff;

   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_valid_ff;
   logic adv1, adv2, adv3, adv4;

   // A stage takes new contents when it is empty or its contents move on.
   assign adv4 = !rsp_valid_ff || !rsp_stall;
   assign adv3 = !s3_v_ff || adv4;
   assign adv2 = !s2_v_ff || adv3;
   assign adv1 = !s1_v_ff || adv2;
   assign req_stall = !adv1;

   assign day[0]   = req_first_day;
   assign month[0] = req_first_month;
   assign year[0]  = req_first_year;
   assign day[1]   = req_second_day;
   assign month[1] = req_second_month;
   assign year[1]  = req_second_year;

   // Stage 1: range checks, month tables, and the reciprocal products for /100.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s1_in[i].yr      = year[i];
         s1_in[i].prev_yr = year[i] - gdd_pkg::YEAR_W'(1);
         s1_in[i].prod_p  = gdd_pkg::PROD_W'(s1_in[i].prev_yr[gdd_pkg::YEAR_W-1:2])
                            * gdd_pkg::PROD_W'(gdd_pkg::RECIP_25);
         s1_in[i].prod_y  = gdd_pkg::PROD_W'(year[i][gdd_pkg::YEAR_W-1:2])
                            * gdd_pkg::PROD_W'(gdd_pkg::RECIP_25);
         s1_in[i].base_ok = (year[i] != '0)
                            && (gdd_pkg::YCMP_W'(year[i]) <= gdd_pkg::YCMP_W'(MAX_YEAR))
                            && (month[i] >= gdd_pkg::MONTH_JAN)
                            && (month[i] <= gdd_pkg::MONTH_DEC)
                            && (day[i] != '0);
         s1_in[i].fit     = day[i] <= gdd_pkg::month_days(month[i]);
         s1_in[i].feb29   = (month[i] == gdd_pkg::MONTH_FEB)
                            && (day[i] == gdd_pkg::FEB_LEAP_DAY);
         s1_in[i].doy     = gdd_pkg::days_before(month[i]) + gdd_pkg::DOY_W'(day[i]);
         s1_in[i].late    = month[i] > gdd_pkg::MONTH_FEB;
      end
   end

   // Stage 2: centuries, the leap rule, and the days in all earlier years.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         logic [gdd_pkg::CENT_W-1:0] cent_p;
         logic [gdd_pkg::CENT_W-1:0] cent_y;
         logic                       by_cent;
         logic                       leap;
         cent_p  = s1_ff[i].prod_p[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SH];
         cent_y  = s1_ff[i].prod_y[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SH];
         by_cent = s1_ff[i].yr
                   == gdd_pkg::YEAR_W'(16'(cent_y) * gdd_pkg::YEARS_PER_CENT);
         leap    = (s1_ff[i].yr[1:0] == 2'b00) && (!by_cent || (cent_y[1:0] == 2'b00));
         s2_in[i].nyear    = gdd_pkg::DAYNUM_W'(s1_ff[i].prev_yr) * gdd_pkg::DAYS_PER_YEAR
                             + gdd_pkg::DAYNUM_W'(s1_ff[i].prev_yr[gdd_pkg::YEAR_W-1:2])
                             - gdd_pkg::DAYNUM_W'(cent_p)
                             + gdd_pkg::DAYNUM_W'(cent_p[gdd_pkg::CENT_W-1:2]);
         s2_in[i].doy      = s1_ff[i].doy;
         s2_in[i].leap_add = leap && s1_ff[i].late;
         s2_in[i].ok       = s1_ff[i].base_ok
                             && (s1_ff[i].fit || (s1_ff[i].feb29 && leap));
      end
   end

   // Stage 3: full day numbers.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s3_num_in[i] = s2_ff[i].nyear + gdd_pkg::DAYNUM_W'(s2_ff[i].doy)
                        + gdd_pkg::DAYNUM_W'(s2_ff[i].leap_add);
      end
      s3_ok_in = s2_ff[0].ok && s2_ff[1].ok;
   end

   // Stage 4: absolute difference, saturated, forced to zero for a bad date.
   always_comb begin
      diff = (s3_num_ff[0] >= s3_num_ff[1]) ? (s3_num_ff[0] - s3_num_ff[1])
                                            : (s3_num_ff[1] - s3_num_ff[0]);
      if (!s3_ok_ff) begin
         rsp_day_count_in = '0;
      end else if (diff > gdd_pkg::DAYNUM_W'(gdd_pkg::COUNT_MAX)) begin
         rsp_day_count_in = gdd_pkg::COUNT_MAX;
      end else begin
         rsp_day_count_in = diff[gdd_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_v_ff      <= req_valid;
         if (adv2) s2_v_ff      <= s1_v_ff;
         if (adv3) s3_v_ff      <= s2_v_ff;
         if (adv4) rsp_valid_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_num_ff <= s3_num_in;
         s3_ok_ff  <= s3_ok_in;
      end
      if (adv4) begin
         rsp_day_count_ff   <= rsp_day_count_in;
         rsp_dates_valid_ff <= s3_ok_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_day_count   = rsp_day_count_ff;
   assign rsp_dates_valid = rsp_dates_valid_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_dates_valid) |-> (rsp_day_count == '0))
      else $error("invalid date pair produced a nonzero count");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && s3_v_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("full pipeline accepted a transaction");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_v_ff)
      else $error("accepted transaction did not enter the first stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && rsp_valid_ff && rsp_stall) |=> (s3_v_ff && $stable(s3_num_ff[0])))
      else $error("stage three changed while the output was stalled");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for gregorian_date_difference: predicts each day count and flag in a scoreboard
// and checks every response in order. Depends on gdd_pkg and the block's top level.
module testbench;

   localparam int YEAR_LIMIT = 9999;
   localparam int unsigned COUNT_CEIL = (1 << gdd_pkg::COUNT_W) - 1;
   localparam int RANDOM_PAIRS = 1930;
   localparam int PRESSURE_AFTER = 300;
   localparam int PRESSURE_CYCLES = 300;

   typedef struct packed {
      logic [gdd_pkg::DAY_W-1:0]   day;
      logic [gdd_pkg::MONTH_W-1:0] month;
      logic [gdd_pkg::YEAR_W-1:0]  year;
   } cal_date_type;

   typedef struct packed {
      cal_date_type first;
      cal_date_type second;
   } date_pair_type;

   class day_gap_board;
      logic [gdd_pkg::COUNT_W-1:0] count_q[$];
      bit                          valid_q[$];
      int                          failures;

      function new();
         failures = 0;
      endfunction

      static function bit is_leap(int unsigned y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      static function int unsigned month_length(int unsigned m, int unsigned y);
         int unsigned len;
         case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap(y) ? 29 : 28;
            default:               len = 0;
         endcase
         return len;
      endfunction

      static function bit date_fits(cal_date_type dt);
         return (dt.year >= 1) && (dt.year <= YEAR_LIMIT) && (dt.month >= 1) &&
                (dt.month <= 12) && (dt.day >= 1) &&
                (dt.day <= month_length(dt.month, dt.year));
      endfunction

      // Day 1 is the first of January of year 1; months are summed one by one.
      static function int unsigned day_ordinal(cal_date_type dt);
         int unsigned p;
         int unsigned n;
         p = dt.year - 1;
         n = 365 * p + p / 4 - p / 100 + p / 400;
         for (int unsigned k = 1; k < dt.month; k++)
            n += month_length(k, dt.year);
         return n + dt.day;
      endfunction

      function void note_request(date_pair_type pr);
         int unsigned na;
         int unsigned nb;
         int unsigned span;
         if (!date_fits(pr.first) || !date_fits(pr.second)) begin
            count_q.push_back('0);
            valid_q.push_back(1'b0);
         end else begin
            na = day_ordinal(pr.first);
            nb = day_ordinal(pr.second);
            span = (na > nb) ? na - nb : nb - na;
            if (span > COUNT_CEIL)
               span = COUNT_CEIL;
            count_q.push_back(span[gdd_pkg::COUNT_W-1:0]);
            valid_q.push_back(1'b1);
         end
      endfunction

      function void check_response(logic [gdd_pkg::COUNT_W-1:0] count, logic flag);
         logic [gdd_pkg::COUNT_W-1:0] want_count;
         bit                          want_flag;
         if (count_q.size() == 0) begin
            $error("response with nothing expected: rsp_day_count %0d rsp_dates_valid %0b",
                   count, flag);
            failures++;
         end else begin
            want_count = count_q.pop_front();
            want_flag = valid_q.pop_front();
            if (count !== want_count) begin
               $error("rsp_day_count: expected %0d, actual %0d", want_count, count);
               failures++;
            end
            if (flag !== want_flag) begin
               $error("rsp_dates_valid: expected %0b, actual %0b", want_flag, flag);
               failures++;
            end
         end
      endfunction

      function int pending();
         return count_q.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [gdd_pkg::DAY_W-1:0]     req_first_day;
   logic [gdd_pkg::MONTH_W-1:0]   req_first_month;
   logic [gdd_pkg::YEAR_W-1:0]    req_first_year;
   logic [gdd_pkg::DAY_W-1:0]     req_second_day;
   logic [gdd_pkg::MONTH_W-1:0]   req_second_month;
   logic [gdd_pkg::YEAR_W-1:0]    req_second_year;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [gdd_pkg::COUNT_W-1:0]   rsp_day_count;
   logic                          rsp_dates_valid;

   day_gap_board board;
   bit           sender_burst = 1'b0;
   bit           receiver_burst = 1'b0;
   bit           holding_off = 1'b0;

   gregorian_date_difference #(
      .MAX_YEAR(YEAR_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_first_day(req_first_day),
      .req_first_month(req_first_month),
      .req_first_year(req_first_year),
      .req_second_day(req_second_day),
      .req_second_month(req_second_month),
      .req_second_year(req_second_year),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_day_count(rsp_day_count),
      .rsp_dates_valid(rsp_dates_valid)
   );

   always #4 clock = ~clock;

   function automatic cal_date_type make_date(int unsigned d, int unsigned m, int unsigned y);
      cal_date_type dt;
      dt.day = gdd_pkg::DAY_W'(d);
      dt.month = gdd_pkg::MONTH_W'(m);
      dt.year = gdd_pkg::YEAR_W'(y);
      return dt;
   endfunction

   function automatic cal_date_type random_valid_date();
      int unsigned y;
      int unsigned m;
      int unsigned len;
      // Part of the years sit close to century boundaries to exercise the leap rule.
      if ($urandom_range(0, 9) < 7)
         y = $urandom_range(1, YEAR_LIMIT);
      else
         y = $urandom_range(1, 99) * 100 + $urandom_range(0, 8) - 4;
      m = $urandom_range(1, 12);
      len = day_gap_board::month_length(m, y);
      if ($urandom_range(0, 7) == 0)
         return make_date(len, m, y);
      return make_date($urandom_range(1, len), m, y);
   endfunction

   function automatic cal_date_type random_raw_date();
      return make_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
   endfunction

   function automatic date_pair_type random_pair();
      date_pair_type pr;
      int unsigned   pick;
      int unsigned   len;
      pick = $urandom_range(0, 99);
      pr.first = random_valid_date();
      pr.second = random_valid_date();
      if (pick < 10) begin
         pr.second = pr.first;
      end else if (pick < 35) begin
         pr.second.year = pr.first.year;
         len = day_gap_board::month_length(pr.second.month, pr.second.year);
         if (pr.second.day > len)
            pr.second.day = gdd_pkg::DAY_W'(len);
      end else if (pick >= 80 && pick < 92) begin
         case ($urandom_range(0, 2))
            0:       pr.first = random_raw_date();
            1:       pr.second = random_raw_date();
            default: begin
               pr.first = random_raw_date();
               pr.second = random_raw_date();
            end
         endcase
      end else if (pick >= 92) begin
         // One day just past the end of its month.
         if ($urandom_range(0, 1) == 0)
            pr.first.day = gdd_pkg::DAY_W'(
               day_gap_board::month_length(pr.first.month, pr.first.year) + 1);
         else
            pr.second.day = gdd_pkg::DAY_W'(
               day_gap_board::month_length(pr.second.month, pr.second.year) + 1);
      end
      return pr;
   endfunction

   task automatic send_pair(date_pair_type pr);
      int unsigned gap;
      if ($urandom_range(0, 49) == 0)
         sender_burst = ~sender_burst;
      gap = (sender_burst || holding_off) ? 0 : $urandom_range(0, 16);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_first_day = pr.first.day;
      req_first_month = pr.first.month;
      req_first_year = pr.first.year;
      req_second_day = pr.second.day;
      req_second_month = pr.second.month;
      req_second_year = pr.second.year;
      do
         @(posedge clock);
      while (req_stall);
      board.note_request(pr);
   endtask

   // Response side: random stalls per transaction, plus one long hold-off.
   initial begin
      int          taken;
      int unsigned wait_cycles;
      taken = 0;
      rsp_stall = 1'b0;
      do
         @(negedge clock);
      while (reset);
      forever begin
         if (taken == PRESSURE_AFTER) begin
            holding_off = 1'b1;
            repeat (PRESSURE_CYCLES) begin
               @(negedge clock);
               rsp_stall = 1'b1;
            end
            holding_off = 1'b0;
         end
         if ($urandom_range(0, 49) == 0)
            receiver_burst = ~receiver_burst;
         wait_cycles = receiver_burst ? 0 : $urandom_range(0, 16);
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do
            @(posedge clock);
         while (!rsp_valid);
         board.check_response(rsp_day_count, rsp_dates_valid);
         taken++;
      end
   end

   initial begin
      date_pair_type directed[$];
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_day = '0;
      req_first_month = '0;
      req_first_year = '0;
      req_second_day = '0;
      req_second_month = '0;
      req_second_year = '0;

      directed.push_back({make_date(1, 1, 1), make_date(1, 1, 1)});
      directed.push_back({make_date(1, 1, 1), make_date(31, 12, 9999)});
      directed.push_back({make_date(31, 12, 9999), make_date(1, 1, 1)});
      directed.push_back({make_date(1, 1, 1), make_date(1, 1, 2)});
      directed.push_back({make_date(29, 2, 2000), make_date(1, 3, 2000)});
      directed.push_back({make_date(29, 2, 2004), make_date(28, 2, 2003)});
      directed.push_back({make_date(28, 2, 2100), make_date(1, 3, 2100)});
      directed.push_back({make_date(31, 12, 2099), make_date(1, 1, 2100)});
      directed.push_back({make_date(15, 6, 1582), make_date(4, 7, 1776)});
      directed.push_back({make_date(29, 2, 1900), make_date(1, 1, 1900)});
      directed.push_back({make_date(30, 2, 2000), make_date(1, 1, 2000)});
      directed.push_back({make_date(1, 5, 2020), make_date(0, 5, 2020)});
      directed.push_back({make_date(31, 4, 2021), make_date(1, 4, 2021)});
      directed.push_back({make_date(31, 12, 1999), make_date(31, 13, 1999)});
      directed.push_back({make_date(1, 0, 1999), make_date(1, 1, 1999)});
      directed.push_back({make_date(1, 15, 1999), make_date(1, 1, 1999)});
      directed.push_back({make_date(1, 1, 0), make_date(1, 1, 1)});
      directed.push_back({make_date(1, 1, 9999), make_date(1, 1, 10000)});
      directed.push_back({make_date(1, 1, 16383), make_date(1, 1, 9999)});
      directed.push_back({make_date(31, 15, 16383), make_date(31, 15, 16383)});
      directed.push_back({make_date(0, 0, 0), make_date(0, 0, 0)});
      directed.push_back({make_date(0, 1, 1), make_date(31, 12, 9999)});
      directed.push_back({make_date(30, 11, 4321), make_date(30, 11, 4321)});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[k])
         send_pair(directed[k]);
      repeat (RANDOM_PAIRS)
         send_pair(random_pair());
      @(negedge clock);
      req_valid = 1'b0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // The slowest correct run needs well under a tenth of this.
   initial begin
      #(20_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
